### hw/rtl/sha1h_pkg.sv
`default_nettype none

package sha1h_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [4:0] chain_t;

    // Default depth of the word queue between the front and the back.
    localparam int unsigned QUEUE_DEPTH_DEF = 16;

    localparam word_t K_R00 = 32'h5a827999;
    localparam word_t K_R20 = 32'h6ed9eba1;
    localparam word_t K_R40 = 32'h8f1bbcdc;
    localparam word_t K_R60 = 32'hca62c1d6;

    localparam word_t IV0 = 32'h67452301;
    localparam word_t IV1 = 32'hefcdab89;
    localparam word_t IV2 = 32'h98badcfe;
    localparam word_t IV3 = 32'h10325476;
    localparam word_t IV4 = 32'hc3d2e1f0;

    // Packed so that index 0 holds the most significant digest word.
    localparam chain_t SHA1_IV = {IV4, IV3, IV2, IV1, IV0};

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [7:0] PAD_ZERO   = 8'h00;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] BLOCK_LAST = 6'd63;
    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [6:0] SCHED_LOAD = 7'd16;
    localparam logic [6:0] ROUND_20   = 7'd20;
    localparam logic [6:0] ROUND_40   = 7'd40;
    localparam logic [6:0] ROUND_60   = 7'd60;
    localparam logic [2:0] LAST_IDX   = 3'd4;
    localparam logic [63:0] BYTE_BITS = 64'd8;

    typedef enum logic [1:0] {
        FE_ACCEPT,
        FE_MARK,
        FE_ZERO,
        FE_LEN
    } front_state_t;

    typedef enum logic [1:0] {
        BK_ROUND,
        BK_ADD,
        BK_EMIT
    } back_state_t;

    // One message word on its way to the compression core. msg_end marks the
    // last word of the last block of a message.
    typedef struct packed {
        logic  msg_end;
        word_t word;
    } qentry_t;

    typedef struct packed {
        logic    valid;
        qentry_t entry;
    } qslot_t;

    function automatic word_t rol(input word_t x, input int unsigned n);
        word_t res;
        res = (x << n) | (x >> (32 - n));
        return res;
    endfunction

    function automatic word_t round_f(input logic [6:0] r, input word_t b,
                                      input word_t c, input word_t d);
        word_t res;
        if (r < ROUND_20) begin
            res = (b & c) | (~b & d);
        end
        else if (r < ROUND_40) begin
            res = b ^ c ^ d;
        end
        else if (r < ROUND_60) begin
            res = (b & c) | (b & d) | (c & d);
        end
        else begin
            res = b ^ c ^ d;
        end
        return res;
    endfunction

    function automatic word_t round_k(input logic [6:0] r);
        word_t res;
        if (r < ROUND_20) begin
            res = K_R00;
        end
        else if (r < ROUND_40) begin
            res = K_R20;
        end
        else if (r < ROUND_60) begin
            res = K_R40;
        end
        else begin
            res = K_R60;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/sha1h_byte_if.sv
`default_nettype none

interface sha1h_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_data;
    logic       last_byte;

    modport source (output valid, output data_byte, output has_data, output last_byte,
                    input ready);
    modport sink (input valid, input data_byte, input has_data, input last_byte,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/sha1h_digest_if.sv
`default_nettype none

interface sha1h_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/sha1h_front.sv
`default_nettype none

module sha1h_front
    import sha1h_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sha1h_byte_if.sink msg,
    input  wire logic  q_full,
    output qslot_t     push
);

    front_state_t state_reg, state_next;
    logic [5:0]   pos_reg, pos_next;
    logic [23:0]  acc_reg, acc_next;
    logic [63:0]  bits_reg, bits_next;

    logic        step;
    logic        end_word;
    logic [7:0]  cur_byte;
    logic [5:0]  pos_inc;
    logic [63:0] len_shift;

    assign pos_inc   = pos_reg + 6'd1;
    // Length bytes go out most significant first: byte 56 carries bits 63..56.
    assign len_shift = bits_reg >> {~pos_reg[2:0], 3'b000};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= FE_ACCEPT;
            pos_reg   <= '0;
            bits_reg  <= '0;
        end
        else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            bits_reg  <= bits_next;
        end
    end

    always_ff @(posedge clk) begin
        acc_reg <= acc_next;
    end

    always_comb begin
        state_next = state_reg;
        bits_next  = bits_reg;
        msg.ready  = 1'b0;
        step       = 1'b0;
        cur_byte   = PAD_ZERO;
        end_word   = 1'b0;
        unique case (state_reg)
            FE_ACCEPT: begin
                msg.ready = !q_full;
                cur_byte  = msg.data_byte;
                if (msg.valid && !q_full) begin
                    step = msg.has_data;
                    if (msg.has_data) begin
                        bits_next = bits_reg + BYTE_BITS;
                    end
                    if (msg.last_byte) begin
                        state_next = FE_MARK;
                    end
                end
            end
            FE_MARK: begin
                step     = !q_full;
                cur_byte = PAD_MARK;
                if (step) begin
                    state_next = (pos_inc == LEN_POS) ? FE_LEN : FE_ZERO;
                end
            end
            FE_ZERO: begin
                step = !q_full;
                if (step && pos_inc == LEN_POS) begin
                    state_next = FE_LEN;
                end
            end
            FE_LEN: begin
                step     = !q_full;
                cur_byte = len_shift[7:0];
                end_word = (pos_reg == BLOCK_LAST);
                if (step && pos_reg == BLOCK_LAST) begin
                    state_next = FE_ACCEPT;
                    bits_next  = '0;
                end
            end
            default: begin
                state_next = FE_ACCEPT;
            end
        endcase
    end

    always_comb begin
        pos_next = pos_reg;
        acc_next = acc_reg;
        if (step) begin
            pos_next = pos_inc;
            acc_next = {acc_reg[15:0], cur_byte};
        end
    end

    // A word is complete on every fourth byte of the block.
    assign push.valid         = step && (pos_reg[1:0] == 2'b11);
    assign push.entry.msg_end = end_word;
    assign push.entry.word    = {acc_reg, cur_byte};

endmodule

`default_nettype wire

### hw/rtl/sha1h_queue.sv
`default_nettype none

module sha1h_queue
    import sha1h_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire qslot_t push,
    output logic        full,
    output qslot_t      head,
    input  wire logic   pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    qentry_t          entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push.valid) begin
            entries_reg[wr_ptr_reg] <= push.entry;
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push.valid) begin
            count_next = count_reg - 1'b1;
        end
    end

    assign full       = (count_reg == CNT_FULL);
    assign head.valid = (count_reg != '0);
    assign head.entry = entries_reg[rd_ptr_reg];

endmodule

`default_nettype wire

### hw/rtl/sha1h_back.sv
`default_nettype none

module sha1h_back
    import sha1h_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire qslot_t     head,
    output logic            pop,
    sha1h_digest_if.source  digest
);

    back_state_t state_reg, state_next;
    logic [6:0]  round_reg, round_next;
    logic [2:0]  idx_reg, idx_next;
    logic        end_reg, end_next;
    chain_t      h_reg, h_next;
    word_t       a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t       a_next, b_next, c_next, d_next, e_next;
    word_t       w_reg [16];
    word_t       w_next [16];

    logic        out_valid_reg, out_valid_next;
    word_t       out_word_reg, out_word_next;
    logic [2:0]  out_idx_reg, out_idx_next;

    logic  loading;
    logic  advance;
    logic  emit;
    word_t sched_word;
    word_t wt;
    word_t temp;

    assign loading    = (round_reg < SCHED_LOAD);
    assign sched_word = rol(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0], 1);
    assign wt         = loading ? head.entry.word : sched_word;
    assign temp       = rol(a_reg, 5) + round_f(round_reg, b_reg, c_reg, d_reg)
                        + e_reg + round_k(round_reg) + wt;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= BK_ROUND;
            round_reg     <= '0;
            idx_reg       <= '0;
            end_reg       <= 1'b0;
            h_reg         <= SHA1_IV;
            a_reg         <= IV0;
            b_reg         <= IV1;
            c_reg         <= IV2;
            d_reg         <= IV3;
            e_reg         <= IV4;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            idx_reg       <= idx_next;
            end_reg       <= end_next;
            h_reg         <= h_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            c_reg         <= c_next;
            d_reg         <= d_next;
            e_reg         <= e_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        w_reg        <= w_next;
        out_word_reg <= out_word_next;
        out_idx_reg  <= out_idx_next;
    end

    always_comb begin
        state_next = state_reg;
        round_next = round_reg;
        idx_next   = idx_reg;
        end_next   = end_reg;
        h_next     = h_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        w_next     = w_reg;
        pop        = 1'b0;
        advance    = 1'b0;
        emit       = 1'b0;
        unique case (state_reg)
            BK_ROUND: begin
                advance = !loading || head.valid;
                pop     = loading && head.valid;
                if (advance) begin
                    for (int i = 0; i < 15; i++) begin
                        w_next[i] = w_reg[i + 1];
                    end
                    w_next[15] = wt;
                    a_next = temp;
                    b_next = a_reg;
                    c_next = rol(b_reg, 30);
                    d_next = c_reg;
                    e_next = d_reg;
                    if (pop && head.entry.msg_end) begin
                        end_next = 1'b1;
                    end
                    if (round_reg == ROUND_LAST) begin
                        round_next = '0;
                        state_next = BK_ADD;
                    end
                    else begin
                        round_next = round_reg + 7'd1;
                    end
                end
            end
            BK_ADD: begin
                h_next[0] = h_reg[0] + a_reg;
                h_next[1] = h_reg[1] + b_reg;
                h_next[2] = h_reg[2] + c_reg;
                h_next[3] = h_reg[3] + d_reg;
                h_next[4] = h_reg[4] + e_reg;
                a_next    = h_next[0];
                b_next    = h_next[1];
                c_next    = h_next[2];
                d_next    = h_next[3];
                e_next    = h_next[4];
                idx_next  = '0;
                state_next = end_reg ? BK_EMIT : BK_ROUND;
            end
            BK_EMIT: begin
                emit = !out_valid_reg || digest.ready;
                if (emit) begin
                    if (idx_reg == LAST_IDX) begin
                        h_next     = SHA1_IV;
                        a_next     = IV0;
                        b_next     = IV1;
                        c_next     = IV2;
                        d_next     = IV3;
                        e_next     = IV4;
                        end_next   = 1'b0;
                        idx_next   = '0;
                        state_next = BK_ROUND;
                    end
                    else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = BK_ROUND;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_idx_next   = out_idx_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            out_word_next  = h_reg[idx_reg];
            out_idx_next   = idx_reg;
        end
        else if (digest.ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign digest.valid       = out_valid_reg;
    assign digest.digest_word = out_word_reg;
    assign digest.word_index  = out_idx_reg;
    assign digest.last_word   = (out_idx_reg == LAST_IDX);

endmodule

`default_nettype wire

### hw/rtl/sha1_message_hasher_top.sv
// SHA-1 message hasher. Message bytes arrive one byte per handshake on msg;
// a handshake with last_byte set closes the message (it may carry no
// byte, so an empty message is allowed), and five digest words then leave
// on digest, most significant first, with word_index 0..4 and last_word on
// the fifth. The message length in bits wraps modulo 2^64. A front stage
// takes one byte per cycle while the queue is not full, packs bytes into
// big-endian 32-bit words and, after the last byte, generates the padding
// and length bytes itself at one byte per cycle, again only while the queue
// is not full, holding msg.ready low meanwhile. Words pass through a queue
// (16 deep by default, one full block) to the compression core, which runs
// one round per cycle, stalling in rounds 0..15 while the queue is empty:
// 80 rounds, then a fold of the result into the chaining words, while the
// front fills the next block. Ending a message adds 9 to 72 padding and
// length bytes ahead of the five digest words. No clearing pass is needed
// after reset.
`default_nettype none

module sha1_message_hasher_top
    import sha1h_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    sha1h_byte_if.sink     msg,
    sha1h_digest_if.source digest
);

    // Words from the front into the queue, and the queue head into the core.
    qslot_t push;
    qslot_t head;
    logic   q_full;
    logic   pop;

    sha1h_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg),
        .q_full (q_full),
        .push   (push)
    );

    sha1h_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .head  (head),
        .pop   (pop)
    );

    sha1h_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .digest (digest)
    );

    // The front must never write into a full queue, or a word would be lost.
    assert property (@(posedge clk) disable iff (!rst_n) push.valid |-> !q_full)
        else $error("word pushed into a full queue");

    // The core must only take words that are really there.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head.valid)
        else $error("word popped from an empty queue");

    // The closing digest word is always the fifth one.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (digest.valid && digest.last_word) |-> (digest.word_index == LAST_IDX))
        else $error("last digest word carries a wrong index");

endmodule

`default_nettype wire
